[rtl/bptc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

  // Joint count per leg and the slot layout of the stores (slot = 2 * joint + leg).
  localparam int JOINTS = 3;
  localparam int SLOTS = 2 * JOINTS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  // Field widths.
  localparam int GAIN_W = 13;
  localparam int CODE_W = 12;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0] GAIN_P_RESET = 13'd960;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET = 13'd819;

  // Mid-scale codes that a joint slot reads before its first reply.
  localparam logic [15:0] POS_MID = 16'd32767;
  localparam logic [11:0] VEL_MID = 12'd2047;

  // Damping codes placed in the command frames.
  localparam logic [CODE_W-1:0] KD_BODY = 12'd8;
  localparam logic [CODE_W-1:0] KD_KNEE = 12'd4;

  // Torque numerator scale factors over a common denominator. The knee uses
  // two thirds of the position gain and four ninths of the damping gain.
  localparam logic signed [22:0] CP_BODY = 23'sd3931200;
  localparam logic signed [22:0] CP_KNEE = 23'sd2620800;
  localparam logic signed [22:0] CV_BODY = 23'sd2359260;
  localparam logic signed [22:0] CV_KNEE = 23'sd1048560;

  // Clamp limit (18 N*m) and full span (36 N*m) on the numerator scale.
  localparam logic signed [54:0] TQ_LIM = 55'sd2967911331840;
  localparam logic signed [54:0] TQ_SPAN = 55'sd5935822663680;

  // The torque code is floor(span_value / 2^12 / 353889). The second division
  // is a multiply by this rounded-up reciprocal of 353889, scaled by 2^50,
  // followed by a right shift of 50; it is exact for every value below 2^31.
  localparam logic [31:0] TQ_RECIP = 32'd3181505803;

  // Frame stored for every slot after reset: zero torque, zero kd.
  localparam logic [63:0] FRAME_RESET = {8'h7F, 8'hFF, 8'h7F, 8'hF0, 8'h00, 12'd0, 12'd2047};

  // Request into the torque unit.
  typedef struct packed {
    logic start;
    logic knee;
    logic signed [16:0] dp;
    logic signed [12:0] dv;
  } tq_req_t;

  // Response from the torque unit.
  typedef struct packed {
    logic done;
    logic [CODE_W-1:0] code;
  } tq_rsp_t;

  // Motor command frame with zero position, velocity and kp.
  function automatic logic [63:0] pack_frame(input logic [CODE_W-1:0] kd,
                                             input logic [CODE_W-1:0] tq);
    pack_frame = {8'h7F, 8'hFF, 8'h7F, 8'hF0, 8'h00, kd, tq};
  endfunction

endpackage

`default_nettype wire

[rtl/bptc_torque.sv]
`timescale 1ns / 1ps
`default_nettype none

module bptc_torque import bptc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [GAIN_W-1:0]   gain_p,
  input  logic [GAIN_W-1:0]   gain_d,
  input  tq_req_t             req,
  output tq_rsp_t             rsp
);

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_SCALE = 3'd1;
  localparam logic [2:0] T_SUM   = 3'd2;
  localparam logic [2:0] T_LIM   = 3'd3;
  localparam logic [2:0] T_RECIP = 3'd4;

  logic [2:0] state;
  logic done;

  logic knee;
  logic signed [30:0] pg;
  logic signed [26:0] vg;
  logic signed [53:0] pn;
  logic signed [49:0] vn;
  logic signed [54:0] n;
  logic [30:0] rem;
  logic [62:0] prod;
  logic [CODE_W-1:0] quo;

  logic signed [30:0] gp_x;
  logic signed [30:0] dp_x;
  logic signed [26:0] gd_x;
  logic signed [26:0] dv_x;
  logic signed [53:0] pg_x;
  logic signed [53:0] cp_x;
  logic signed [49:0] vg_x;
  logic signed [49:0] cv_x;
  logic signed [54:0] m_full;
  logic [42:0] m_clamp;

  // Operand extension for the two multiplier stages.
  always_comb begin
    gp_x = $signed({18'd0, gain_p});
    dp_x = 31'(req.dp);
    gd_x = $signed({14'd0, gain_d});
    dv_x = 27'(req.dv);
    pg_x = 54'(pg);
    cp_x = knee ? 54'(CP_KNEE) : 54'(CP_BODY);
    vg_x = 50'(vg);
    cv_x = knee ? 50'(CV_KNEE) : 50'(CV_BODY);
  end

  // Clamp to +-18 N*m and shift the range to start at zero.
  always_comb begin
    m_full = n + TQ_LIM;
    if (m_full < 55'sd0) begin
      m_clamp = '0;
    end else if (m_full > TQ_SPAN) begin
      m_clamp = TQ_SPAN[42:0];
    end else begin
      m_clamp = m_full[42:0];
    end
  end

  // Division by the constant as a multiply with its scaled reciprocal.
  assign prod = 63'(rem) * 63'(TQ_RECIP);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (req.start) begin
            state <= T_SCALE;
          end
        end
        T_SCALE: state <= T_SUM;
        T_SUM: state <= T_LIM;
        T_LIM: state <= T_RECIP;
        T_RECIP: begin
          done <= 1'b1;
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        if (req.start) begin
          pg <= gp_x * dp_x;
          vg <= gd_x * dv_x;
          knee <= req.knee;
        end
      end
      T_SCALE: begin
        pn <= pg_x * cp_x;
        vn <= vg_x * cv_x;
      end
      T_SUM: n <= 55'(pn) + 55'(vn);
      T_LIM: rem <= m_clamp[42:12];
      T_RECIP: quo <= CODE_W'(prod >> 50);
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.code = quo;

  // A new request only arrives while the unit is free.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == T_IDLE))
    else $error("torque request while busy");

  // The reciprocal step always follows the clamp.
  a_lim_recip: assert property (@(posedge clk) disable iff (rst)
    (state == T_LIM) |=> (state == T_RECIP))
    else $error("reciprocal step did not follow the clamp");

  // The reciprocal step reports completion.
  a_recip_done: assert property (@(posedge clk) disable iff (rst)
    (state == T_RECIP) |=> (done && state == T_IDLE))
    else $error("torque finished without done");

endmodule

`default_nettype wire

[rtl/bilateral_pd_teleop_can_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A reply transaction gives no result.
// An enabled tick runs each of its six frames through two store-read states, the
// torque unit (two multiplier stages, a sum, a clamp and a reciprocal multiply)
// and one emit state; output stalls hold a frame in the emit state.
// A disabled tick reads each of its six frames from the frame store and emits it.
// Reset loads the default gains, clears run_enable and marks every store entry
// unwritten, so joints read mid-scale codes and frames read zero torque.

module bilateral_pd_teleop_can_unit import bptc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic                  leg,
  input  logic [7:0]            reply_byte0,
  input  logic [7:0]            reply_byte1,
  input  logic [7:0]            reply_byte2,
  input  logic [7:0]            reply_byte3,
  input  logic [7:0]            reply_byte4,
  input  logic [7:0]            reply_byte5,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  bus,
  output logic [1:0]            frame_id,
  output logic [7:0]            cmd_byte0,
  output logic [7:0]            cmd_byte1,
  output logic [7:0]            cmd_byte2,
  output logic [7:0]            cmd_byte3,
  output logic [7:0]            cmd_byte4,
  output logic [7:0]            cmd_byte5,
  output logic [7:0]            cmd_byte6,
  output logic [7:0]            cmd_byte7,
  output logic                  last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_JRD  = 3'd1;
  localparam logic [2:0] ST_JDAT = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_FRD  = 3'd4;
  localparam logic [2:0] ST_FDAT = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_d;
  logic run_enable;

  // Control state.
  logic [2:0] state;
  logic [SLOT_W-1:0] slot;
  logic refresh;

  // Joint store: position code over velocity code.
  logic [27:0] jmem [SLOTS];
  logic [SLOTS-1:0] jvalid;
  logic [27:0] jrd_self;
  logic [27:0] jrd_other;
  logic jv_self;
  logic jv_other;

  // Frame store.
  logic [63:0] fmem [SLOTS];
  logic [SLOTS-1:0] fvalid;
  logic [63:0] frd;
  logic fv;

  // Frame waiting for the output register, and the output register.
  logic [63:0] frame;
  logic [63:0] out_frame;

  logic in_fire;
  logic reply_ok;
  logic [SLOT_W-1:0] reply_slot;
  logic [SLOT_W-1:0] other;
  logic out_free;
  logic emit;
  logic fmem_we;
  logic knee;
  logic [15:0] pos_s;
  logic [15:0] pos_o;
  logic [11:0] vel_s;
  logic [11:0] vel_o;

  tq_req_t tq_req;
  tq_rsp_t tq_rsp;

  // Handshake and address decode.
  assign in_ready = (state == ST_IDLE);
  assign in_fire = in_valid & in_ready;
  assign reply_ok = !kind && (reply_byte0 != 8'd0) && (reply_byte0 <= 8'(JOINTS));
  assign reply_slot = SLOT_W'({reply_byte0 - 8'd1, leg});
  assign other = slot ^ SLOT_W'(1);
  assign out_free = !out_valid || out_ready;
  assign emit = (state == ST_EMIT) && out_free;
  assign fmem_we = emit && refresh;
  assign knee = ((32'(slot) >> 1) >= 32'd2);

  // Unwritten joint slots read as mid-scale codes.
  assign pos_s = jv_self ? jrd_self[27:12] : POS_MID;
  assign vel_s = jv_self ? jrd_self[11:0] : VEL_MID;
  assign pos_o = jv_other ? jrd_other[27:12] : POS_MID;
  assign vel_o = jv_other ? jrd_other[11:0] : VEL_MID;

  // Mirrored differences: the other leg minus this leg.
  assign tq_req.start = (state == ST_JDAT);
  assign tq_req.knee = knee;
  assign tq_req.dp = $signed({1'b0, pos_o}) - $signed({1'b0, pos_s});
  assign tq_req.dv = $signed({1'b0, vel_o}) - $signed({1'b0, vel_s});

  bptc_torque u_torque (
    .clk    (clk),
    .rst    (rst),
    .gain_p (gain_p),
    .gain_d (gain_d),
    .req    (tq_req),
    .rsp    (tq_rsp)
  );

  // Joint store: written by replies, read at both legs of one joint.
  always_ff @(posedge clk) begin
    if (in_fire && reply_ok) begin
      jmem[reply_slot] <= {reply_byte1, reply_byte2, reply_byte3, reply_byte4[7:4]};
    end
    if (state == ST_JRD) begin
      jrd_self <= jmem[slot];
      jrd_other <= jmem[other];
    end
  end

  // Frame store: written on refresh, read when frames are repeated.
  always_ff @(posedge clk) begin
    if (fmem_we) begin
      fmem[slot] <= frame;
    end
    if (state == ST_FRD) begin
      frd <= fmem[slot];
    end
  end

  // Written marks for both stores, read alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      jvalid <= '0;
      fvalid <= '0;
      jv_self <= 1'b0;
      jv_other <= 1'b0;
      fv <= 1'b0;
    end else begin
      if (in_fire && reply_ok) begin
        jvalid[reply_slot] <= 1'b1;
      end
      if (fmem_we) begin
        fvalid[slot] <= 1'b1;
      end
      if (state == ST_JRD) begin
        jv_self <= jvalid[slot];
        jv_other <= jvalid[other];
      end
      if (state == ST_FRD) begin
        fv <= fvalid[slot];
      end
    end
  end

  // Configuration, sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= GAIN_P_RESET;
      gain_d <= GAIN_D_RESET;
      run_enable <= 1'b0;
      state <= ST_IDLE;
      slot <= '0;
      refresh <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_P: gain_p <= cfg_data;
          REG_GAIN_D: gain_d <= cfg_data;
          REG_RUN: run_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire && kind) begin
            slot <= '0;
            refresh <= run_enable;
            state <= run_enable ? ST_JRD : ST_FRD;
          end
        end
        ST_JRD: state <= ST_JDAT;
        ST_JDAT: state <= ST_CALC;
        ST_CALC: begin
          if (tq_rsp.done) begin
            state <= ST_EMIT;
          end
        end
        ST_FRD: state <= ST_FDAT;
        ST_FDAT: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            if (slot == SLOT_LAST) begin
              state <= ST_IDLE;
            end else begin
              slot <= slot + SLOT_W'(1);
              state <= refresh ? ST_JRD : ST_FRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Frame assembly and output payload.
  always_ff @(posedge clk) begin
    if (state == ST_CALC && tq_rsp.done) begin
      frame <= pack_frame(knee ? KD_KNEE : KD_BODY, tq_rsp.code);
    end else if (state == ST_FDAT) begin
      frame <= fv ? frd : FRAME_RESET;
    end
    if (emit) begin
      bus <= slot[0];
      frame_id <= 2'((32'(slot) >> 1) + 32'd1);
      out_frame <= frame;
      last <= (slot == SLOT_LAST);
    end
  end

  assign cmd_byte0 = out_frame[63:56];
  assign cmd_byte1 = out_frame[55:48];
  assign cmd_byte2 = out_frame[47:40];
  assign cmd_byte3 = out_frame[39:32];
  assign cmd_byte4 = out_frame[31:24];
  assign cmd_byte5 = out_frame[23:16];
  assign cmd_byte6 = out_frame[15:8];
  assign cmd_byte7 = out_frame[7:0];

  // A finished torque always moves on to the output stage.
  a_calc_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && tq_rsp.done) |=> (state == ST_EMIT))
    else $error("torque result not taken");

  // The sixth frame of a tick carries last and frees the input side.
  a_last_frame: assert property (@(posedge clk) disable iff (rst)
    (emit && slot == SLOT_LAST) |=> (state == ST_IDLE && out_valid && last))
    else $error("last frame not flagged");

  // A reply transaction produces no result and leaves the block idle.
  a_reply_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !kind && !out_valid) |=> (state == ST_IDLE && !out_valid))
    else $error("reply produced a result");

endmodule

`default_nettype wire
